[hdl/atree_pkg.sv]
`default_nettype none

package atree_pkg;

  // fixed field widths of the stream items
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned ORDER_W  = 2;
  localparam int unsigned CHILD_W  = 8;

  // walk stack
  localparam int unsigned STACK_SLOTS = 64;
  localparam int unsigned SLOT_W      = $clog2(STACK_SLOTS);
  localparam int unsigned SP_W        = $clog2(STACK_SLOTS + 1);

  // defaults for the top level parameters
  localparam int unsigned DEF_CAPACITY    = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  localparam logic ACT_APPEND   = 1'b0;
  localparam logic ACT_TRAVERSE = 1'b1;

  typedef enum logic [ORDER_W-1:0] {
    ORD_PRE  = 2'd0,
    ORD_IN   = 2'd1,
    ORD_POST = 2'd2
  } atree_order_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_POP,
    ST_PRE_NODE,
    ST_PRE_LEFT,
    ST_IN_DESC,
    ST_IN_NODE,
    ST_IN_EMIT,
    ST_POST_POP,
    ST_POST_NODE,
    ST_POST_RIGHT,
    ST_POST_LEFT,
    ST_POST_EMIT,
    ST_FINISH
  } atree_state_e;

  // one stack slot: node index plus a flag that marks a node whose
  // children were already expanded (postorder)
  typedef struct packed {
    logic             post;
    logic [IDX_W-1:0] idx;
  } atree_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    atree_entry_t      wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } atree_stack_req_t;

  typedef struct packed {
    logic            idle;
    logic            pend_valid;
    logic [SP_W-1:0] sp;
  } atree_status_t;

endpackage

`default_nettype wire

[hdl/atree_node_mem.sv]
`default_nettype none

module atree_node_mem #(
  parameter int unsigned DEPTH = atree_pkg::DEF_CAPACITY,
  parameter int unsigned WIDTH = atree_pkg::DEF_VALUE_WIDTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/atree_stack_mem.sv]
`default_nettype none

module atree_stack_mem (
  input  wire logic                        clk_i,
  input  wire atree_pkg::atree_stack_req_t req_i,
  output atree_pkg::atree_entry_t          rdata_o
);

  atree_pkg::atree_entry_t mem [atree_pkg::STACK_SLOTS];
  atree_pkg::atree_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/atree_walker.sv]
`default_nettype none

module atree_walker #(
  parameter int unsigned CAPACITY    = atree_pkg::DEF_CAPACITY,
  parameter int unsigned VALUE_WIDTH = atree_pkg::DEF_VALUE_WIDTH,
  localparam int unsigned AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW         = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              in_action_i,
  input  wire logic [atree_pkg::DATA_W-1:0]      in_value_i,
  input  wire logic [atree_pkg::ORDER_W-1:0]     in_order_i,
  input  wire logic [atree_pkg::IDX_W-1:0]       in_start_i,
  // results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [atree_pkg::DATA_W-1:0]      out_value_o,
  output logic      [atree_pkg::IDX_W-1:0]       out_index_o,
  output logic                                   out_last_o,
  // node value memory
  output logic                                   node_we_o,
  output logic      [AW-1:0]                     node_waddr_o,
  output logic      [VALUE_WIDTH-1:0]            node_wdata_o,
  output logic                                   node_re_o,
  output logic      [AW-1:0]                     node_raddr_o,
  input  wire logic [VALUE_WIDTH-1:0]            node_rdata_i,
  // walk stack memory
  output atree_pkg::atree_stack_req_t            stack_req_o,
  input  wire atree_pkg::atree_entry_t           stack_rdata_i,
  output atree_pkg::atree_status_t               status_o
);

  localparam int unsigned SP_W    = atree_pkg::SP_W;
  localparam int unsigned CHILD_W = atree_pkg::CHILD_W;
  localparam int unsigned IDX_W   = atree_pkg::IDX_W;
  localparam int unsigned DATA_W  = atree_pkg::DATA_W;

  atree_pkg::atree_state_e state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [SP_W-1:0]    sp_q, sp_d;
  logic [CHILD_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0]   cur_q, cur_d;

  logic               pend_valid_q;
  logic [IDX_W-1:0]   pend_index_q;
  logic [DATA_W-1:0]  pend_value_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_value_q;
  logic [IDX_W-1:0]   out_index_q;
  logic               out_last_q;

  logic [SP_W-1:0]    sp_m1;
  logic [CHILD_W-1:0] count_ext;
  logic [CHILD_W-1:0] start_ext;
  logic [CHILD_W-1:0] rd_right, cur_left, cur_right;
  logic               out_free, ok_emit, do_emit, do_final;
  logic [VALUE_WIDTH+DATA_W-1:0] in_wide, node_wide;
  logic [DATA_W-1:0]  node_value;

  atree_pkg::atree_stack_req_t stack_req;

  assign sp_m1     = sp_q - SP_W'(1);
  assign count_ext = CHILD_W'(count_q);
  assign start_ext = CHILD_W'(in_start_i);

  // heap children: 2i+1 and 2i+2
  assign rd_right  = {1'b0, stack_rdata_i.idx, 1'b0} + CHILD_W'(2);
  assign cur_left  = {1'b0, cur_q, 1'b1};
  assign cur_right = {1'b0, cur_q, 1'b0} + CHILD_W'(2);

  // values are kept in VALUE_WIDTH bits and come back as their low 32 bits
  assign in_wide    = {{VALUE_WIDTH{1'b0}}, in_value_i};
  assign node_wide  = {{DATA_W{1'b0}}, node_rdata_i};
  assign node_value = node_wide[DATA_W-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  // the previous node can only move on once the output register frees up
  assign ok_emit  = !pend_valid_q || out_free;

  assign in_ready_o   = (state_q == atree_pkg::ST_IDLE);
  assign node_waddr_o = count_q[AW-1:0];
  assign node_wdata_o = in_wide[VALUE_WIDTH-1:0];
  assign node_raddr_o = stack_rdata_i.idx[AW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    sp_d      = sp_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    node_we_o = 1'b0;
    node_re_o = 1'b0;
    do_emit   = 1'b0;
    do_final  = 1'b0;
    stack_req       = '0;
    stack_req.waddr = sp_q[atree_pkg::SLOT_W-1:0];
    stack_req.raddr = sp_m1[atree_pkg::SLOT_W-1:0];

    case (state_q)
      atree_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == atree_pkg::ACT_APPEND) begin
            if (count_q < CW'(CAPACITY)) begin
              node_we_o = 1'b1;
              count_d   = count_q + CW'(1);
            end
          end else if (start_ext < count_ext) begin
            case (in_order_i)
              atree_pkg::ORD_PRE: begin
                stack_req.we    = 1'b1;
                stack_req.wdata = '{post: 1'b0, idx: in_start_i};
                sp_d            = SP_W'(1);
                state_d         = atree_pkg::ST_PRE_POP;
              end
              atree_pkg::ORD_POST: begin
                stack_req.we    = 1'b1;
                stack_req.wdata = '{post: 1'b0, idx: in_start_i};
                sp_d            = SP_W'(1);
                state_d         = atree_pkg::ST_POST_POP;
              end
              atree_pkg::ORD_IN: begin
                idx_d   = start_ext;
                sp_d    = '0;
                state_d = atree_pkg::ST_IN_DESC;
              end
              default: ;
            endcase
          end
        end
      end

      // preorder: pop, read value and push right, then push left and emit
      atree_pkg::ST_PRE_POP: begin
        if (sp_q == '0) begin
          state_d = atree_pkg::ST_FINISH;
        end else begin
          stack_req.re = 1'b1;
          sp_d         = sp_m1;
          state_d      = atree_pkg::ST_PRE_NODE;
        end
      end
      atree_pkg::ST_PRE_NODE: begin
        cur_d     = stack_rdata_i.idx;
        node_re_o = 1'b1;
        if (rd_right < count_ext) begin
          stack_req.we    = 1'b1;
          stack_req.wdata = '{post: 1'b0, idx: rd_right[IDX_W-1:0]};
          sp_d            = sp_q + SP_W'(1);
        end
        state_d = atree_pkg::ST_PRE_LEFT;
      end
      atree_pkg::ST_PRE_LEFT: begin
        if (ok_emit) begin
          do_emit = 1'b1;
          if (cur_left < count_ext) begin
            stack_req.we    = 1'b1;
            stack_req.wdata = '{post: 1'b0, idx: cur_left[IDX_W-1:0]};
            sp_d            = sp_q + SP_W'(1);
          end
          state_d = atree_pkg::ST_PRE_POP;
        end
      end

      // inorder: descend left pushing each node, pop, emit, step right
      atree_pkg::ST_IN_DESC: begin
        if (idx_q < count_ext) begin
          stack_req.we    = 1'b1;
          stack_req.wdata = '{post: 1'b0, idx: idx_q[IDX_W-1:0]};
          sp_d            = sp_q + SP_W'(1);
          idx_d           = {idx_q[CHILD_W-2:0], 1'b1};
        end else if (sp_q != '0) begin
          stack_req.re = 1'b1;
          sp_d         = sp_m1;
          state_d      = atree_pkg::ST_IN_NODE;
        end else begin
          state_d = atree_pkg::ST_FINISH;
        end
      end
      atree_pkg::ST_IN_NODE: begin
        cur_d     = stack_rdata_i.idx;
        node_re_o = 1'b1;
        state_d   = atree_pkg::ST_IN_EMIT;
      end
      atree_pkg::ST_IN_EMIT: begin
        if (ok_emit) begin
          do_emit = 1'b1;
          idx_d   = cur_right;
          state_d = atree_pkg::ST_IN_DESC;
        end
      end

      // postorder: a fresh node goes back flagged under its right and left
      // children; a flagged node is emitted when it comes up again
      atree_pkg::ST_POST_POP: begin
        if (sp_q == '0) begin
          state_d = atree_pkg::ST_FINISH;
        end else begin
          stack_req.re = 1'b1;
          sp_d         = sp_m1;
          state_d      = atree_pkg::ST_POST_NODE;
        end
      end
      atree_pkg::ST_POST_NODE: begin
        cur_d = stack_rdata_i.idx;
        if (stack_rdata_i.post) begin
          node_re_o = 1'b1;
          state_d   = atree_pkg::ST_POST_EMIT;
        end else begin
          stack_req.we    = 1'b1;
          stack_req.wdata = '{post: 1'b1, idx: stack_rdata_i.idx};
          sp_d            = sp_q + SP_W'(1);
          state_d         = atree_pkg::ST_POST_RIGHT;
        end
      end
      atree_pkg::ST_POST_RIGHT: begin
        if (cur_right < count_ext) begin
          stack_req.we    = 1'b1;
          stack_req.wdata = '{post: 1'b0, idx: cur_right[IDX_W-1:0]};
          sp_d            = sp_q + SP_W'(1);
        end
        state_d = atree_pkg::ST_POST_LEFT;
      end
      atree_pkg::ST_POST_LEFT: begin
        if (cur_left < count_ext) begin
          stack_req.we    = 1'b1;
          stack_req.wdata = '{post: 1'b0, idx: cur_left[IDX_W-1:0]};
          sp_d            = sp_q + SP_W'(1);
        end
        state_d = atree_pkg::ST_POST_POP;
      end
      atree_pkg::ST_POST_EMIT: begin
        if (ok_emit) begin
          do_emit = 1'b1;
          state_d = atree_pkg::ST_POST_POP;
        end
      end

      // the held node is the final one of the walk
      atree_pkg::ST_FINISH: begin
        if (!pend_valid_q) begin
          state_d = atree_pkg::ST_IDLE;
        end else if (out_free) begin
          do_final = 1'b1;
          state_d  = atree_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = atree_pkg::ST_IDLE;
      end
    endcase
  end

  assign stack_req_o = stack_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= atree_pkg::ST_IDLE;
      count_q      <= '0;
      sp_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sp_q    <= sp_d;
      if (do_emit) begin
        pend_valid_q <= 1'b1;
      end else if (do_final) begin
        pend_valid_q <= 1'b0;
      end
      if ((do_emit && pend_valid_q) || do_final) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    if (do_emit) begin
      pend_index_q <= cur_q;
      pend_value_q <= node_value;
    end
    if ((do_emit && pend_valid_q) || do_final) begin
      out_value_q <= pend_value_q;
      out_index_q <= pend_index_q;
      out_last_q  <= do_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

  assign status_o.idle       = (state_q == atree_pkg::ST_IDLE);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.sp         = sp_q;

endmodule

`default_nettype wire

[hdl/array_tree_traversal.sv]
// channel   dir  tdata (low bit up)                            tuser      tlast
// s_axis    in   value[31:0] order[33:32] start_index[39:34]   action     -
// m_axis    out  node_value[31:0] node_index[37:32] zeros      -          last
//
// traversal: the walk stack memory (one push or pop a cycle) and the registered
// value read set the pace of each node in preorder, inorder and postorder.
// reset clears node count, stack pointer and the output register; the value
// and stack memories are not cleared. each node is held one step so the final
// one can carry tlast; the walk halts while m_axis stalls.
`default_nettype none

module array_tree_traversal #(
  parameter int unsigned CAPACITY    = atree_pkg::DEF_CAPACITY,
  parameter int unsigned VALUE_WIDTH = atree_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // value[31:0], order[33:32], start_index[39:34]
  input  wire logic [0:0]  s_axis_tuser,  // action[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,  // node_value[31:0], node_index[37:32], zero[39:38]
  output logic             m_axis_tlast   // last
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                               node_we, node_re;
  logic [AW-1:0]                      node_waddr, node_raddr;
  logic [VALUE_WIDTH-1:0]             node_wdata, node_rdata;
  atree_pkg::atree_stack_req_t        stack_req;
  atree_pkg::atree_entry_t            stack_rdata;
  atree_pkg::atree_status_t           status;
  logic [atree_pkg::DATA_W-1:0]       out_value;
  logic [atree_pkg::IDX_W-1:0]        out_index;

  atree_node_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  atree_stack_mem u_stack_mem (
    .clk_i   (clk_i),
    .req_i   (stack_req),
    .rdata_o (stack_rdata)
  );

  atree_walker #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser[0]),
    .in_value_i    (s_axis_tdata[31:0]),
    .in_order_i    (s_axis_tdata[33:32]),
    .in_start_i    (s_axis_tdata[39:34]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_value_o   (out_value),
    .out_index_o   (out_index),
    .out_last_o    (m_axis_tlast),
    .node_we_o     (node_we),
    .node_waddr_o  (node_waddr),
    .node_wdata_o  (node_wdata),
    .node_re_o     (node_re),
    .node_raddr_o  (node_raddr),
    .node_rdata_i  (node_rdata),
    .stack_req_o   (stack_req),
    .stack_rdata_i (stack_rdata),
    .status_o      (status)
  );

  assign m_axis_tdata = {2'b00, out_index, out_value};

  // no node may be held over once the walk is back in idle
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.idle |-> !status.pend_valid)
    else $error("node held while idle");

  // every walk leaves the stack empty
  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.idle |-> (status.sp == '0))
    else $error("walk stack not empty in idle");

  // the stack never runs past its slots
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.sp <= atree_pkg::SP_W'(atree_pkg::STACK_SLOTS))
    else $error("walk stack overflow");

  // a new item is only taken once the previous walk has handed over its last node
  a_accept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (!status.pend_valid && status.idle))
    else $error("item taken during a walk");

endmodule

`default_nettype wire

[dv/tb_array_tree_traversal.sv]
`timescale 1ns / 1ps

module tb_array_tree_traversal;

  localparam int unsigned TREE_SLOTS   = 64;
  localparam int unsigned RAND_ITEMS   = 100;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned MAX_GAP      = 12;

  typedef enum logic [1:0] {
    CHK_MODEL,  // expected beats come from the walk predictor
    CHK_NONE,   // no beat expected
    CHK_ONE     // exactly one beat, typed into the row
  } row_check_e;

  typedef struct packed {
    logic             act;
    logic [31:0]      val;
    logic [1:0]       ord;
    logic [5:0]       start;
    row_check_e       chk;
    logic [31:0]      exp_val;
    logic [5:0]       exp_idx;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] val;
    logic [5:0]  idx;
    logic        last;
  } node_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // value[31:0], order[33:32], start_index[39:34]
  logic [0:0]  s_axis_tuser;   // action[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // node_value[31:0], node_index[37:32], zero[39:38]
  logic        m_axis_tlast;

  // shadow of the tree store
  logic [31:0] tree_vals [TREE_SLOTS];
  int unsigned tree_count;

  node_beat_t  node_beats_q [$];
  node_beat_t  want;
  stim_row_t   dir_tbl [22];

  int unsigned mismatch_cnt = 0;
  int unsigned beats_seen = 0;
  int unsigned items_sent;
  int unsigned drops;
  int unsigned walks [4];
  int unsigned cycle_cnt = 0;

  array_tree_traversal i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, node_beats_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // updates the shadow store and, for a walk, queues the visited nodes
  task automatic walk_tree(input logic act, input logic [31:0] val, input logic [1:0] ord,
                           input logic [5:0] start, input bit queue_beats);
    int unsigned stk [$];
    int unsigned post_stk [$];
    int unsigned seq [$];
    int unsigned cur;
    node_beat_t  nb;
    if (act == atree_pkg::ACT_APPEND) begin
      if (tree_count < TREE_SLOTS) begin
        tree_vals[tree_count] = val;
        tree_count++;
      end else begin
        drops++;
      end
      return;
    end
    walks[ord]++;
    if (!queue_beats || start >= tree_count) return;
    case (atree_pkg::atree_order_e'(ord))
      atree_pkg::ORD_PRE: begin
        stk.push_back(32'(start));
        while (stk.size() > 0) begin
          cur = stk.pop_back();
          if (cur < tree_count) begin
            seq.push_back(cur);
            stk.push_back(2 * cur + 2);
            stk.push_back(2 * cur + 1);
          end
        end
      end
      atree_pkg::ORD_IN: begin
        cur = 32'(start);
        forever begin
          if (cur < tree_count) begin
            stk.push_back(cur);
            cur = 2 * cur + 1;
          end else if (stk.size() > 0) begin
            cur = stk.pop_back();
            seq.push_back(cur);
            cur = 2 * cur + 2;
          end else begin
            break;
          end
        end
      end
      atree_pkg::ORD_POST: begin
        // reversed root-right-left collection gives postorder
        stk.push_back(32'(start));
        while (stk.size() > 0) begin
          cur = stk.pop_back();
          post_stk.push_back(cur);
          if (2 * cur + 1 < tree_count) stk.push_back(2 * cur + 1);
          if (2 * cur + 2 < tree_count) stk.push_back(2 * cur + 2);
        end
        while (post_stk.size() > 0) seq.push_back(post_stk.pop_back());
      end
      default: ;
    endcase
    foreach (seq[k]) begin
      nb.val  = tree_vals[seq[k]];
      nb.idx  = 6'(seq[k]);
      nb.last = (k == seq.size() - 1);
      node_beats_q.push_back(nb);
    end
  endtask

  // drives one item and returns at the edge that accepts it
  task automatic send_item(input logic act, input logic [31:0] val, input logic [1:0] ord,
                           input logic [5:0] start, input int unsigned gap,
                           input bit drain_first);
    if (gap > 0 || drain_first) s_axis_tvalid <= 1'b0;
    if (drain_first) begin
      do @(posedge clk_i); while (node_beats_q.size() != 0);
    end
    repeat (gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {start, ord, val};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // receiver: random stalls per beat, with stall-free stretches
  initial begin
    int unsigned wait_cyc;
    int unsigned nbeat;
    m_axis_tready <= 1'b0;
    nbeat = 0;
    forever begin
      wait_cyc = ((nbeat / 24) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
      if (wait_cyc > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cyc) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      nbeat++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (node_beats_q.size() == 0) begin
        $display("%0t: unexpected beat, exp none, got value %h index %0d last %0b",
                 $time, m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = node_beats_q.pop_front();
        if (m_axis_tdata[31:0] !== want.val) begin
          $display("%0t: node value mismatch, exp %h, got %h", $time, want.val,
                   m_axis_tdata[31:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[37:32] !== want.idx) begin
          $display("%0t: node index mismatch, exp %0d, got %0d", $time, want.idx,
                   m_axis_tdata[37:32]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[39:38] !== 2'b00) begin
          $display("%0t: pad bits mismatch, exp 0, got %b", $time, m_axis_tdata[39:38]);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last flag mismatch, exp %0b, got %0b", $time, want.last,
                   m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned gap;
    int unsigned r;
    logic        act;
    logic [31:0] val;
    logic [1:0]  ord;
    logic [5:0]  start;
    bit          was_full;
    node_beat_t  nb;

    items_sent   = 0;
    drops        = 0;
    tree_count   = 0;
    foreach (walks[i]) walks[i] = 0;

    dir_tbl = '{
      // walks on the empty tree
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_PRE, 6'd0, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'hFFFF_FFFF, atree_pkg::ORD_POST, 6'd63, CHK_NONE, 32'h0,
        6'd0},
      '{atree_pkg::ACT_APPEND, 32'h8000_0000, atree_pkg::ORD_PRE, 6'd0, CHK_NONE, 32'h0, 6'd0},
      // single node tree
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_PRE, 6'd0, CHK_ONE,
        32'h8000_0000, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_IN, 6'd0, CHK_ONE,
        32'h8000_0000, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_POST, 6'd0, CHK_ONE,
        32'h8000_0000, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, 2'd3, 6'd0, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_PRE, 6'd1, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_APPEND, 32'h7FFF_FFFF, 2'd3, 6'd63, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_APPEND, 32'h0000_0000, atree_pkg::ORD_PRE, 6'd0, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_APPEND, 32'hFFFF_FFFF, atree_pkg::ORD_IN, 6'd21, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_APPEND, 32'h0000_0001, atree_pkg::ORD_POST, 6'd42, CHK_NONE, 32'h0,
        6'd0},
      '{atree_pkg::ACT_APPEND, 32'h5555_5555, atree_pkg::ORD_PRE, 6'd0, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_APPEND, 32'hAAAA_AAAA, atree_pkg::ORD_PRE, 6'd0, CHK_NONE, 32'h0, 6'd0},
      // seven node tree
      '{atree_pkg::ACT_TRAVERSE, 32'hFFFF_FFFF, atree_pkg::ORD_PRE, 6'd0, CHK_MODEL, 32'h0,
        6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_IN, 6'd0, CHK_MODEL, 32'h0, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'hFFFF_FFFF, atree_pkg::ORD_POST, 6'd0, CHK_MODEL, 32'h0,
        6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_POST, 6'd2, CHK_MODEL, 32'h0,
        6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_IN, 6'd1, CHK_MODEL, 32'h0, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_PRE, 6'd6, CHK_ONE,
        32'hAAAA_AAAA, 6'd6},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, atree_pkg::ORD_PRE, 6'd7, CHK_NONE, 32'h0, 6'd0},
      '{atree_pkg::ACT_TRAVERSE, 32'h0000_0000, 2'd3, 6'd0, CHK_NONE, 32'h0, 6'd0}
    };

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i].act, dir_tbl[i].val, dir_tbl[i].ord, dir_tbl[i].start,
                $urandom_range(0, MAX_GAP), 1'b0);
      walk_tree(dir_tbl[i].act, dir_tbl[i].val, dir_tbl[i].ord, dir_tbl[i].start,
                dir_tbl[i].chk == CHK_MODEL);
      if (dir_tbl[i].chk == CHK_ONE) begin
        nb.val  = dir_tbl[i].exp_val;
        nb.idx  = dir_tbl[i].exp_idx;
        nb.last = 1'b1;
        node_beats_q.push_back(nb);
      end
    end

    // mostly appends until the store fills, then mostly walks of the full tree
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      val   = $urandom();
      ord   = 2'($urandom_range(0, 3));
      start = 6'($urandom_range(0, 63));
      r     = $urandom_range(0, 99);
      act   = (tree_count < TREE_SLOTS)
              ? (r < 70 ? atree_pkg::ACT_APPEND : atree_pkg::ACT_TRAVERSE)
              : (r < 10 ? atree_pkg::ACT_APPEND : atree_pkg::ACT_TRAVERSE);
      if (act == atree_pkg::ACT_TRAVERSE) begin
        r   = $urandom_range(0, 15);
        ord = (r == 15) ? 2'd3 : 2'(r % 3);
        r   = $urandom_range(0, 3);
        if (r == 0) start = 6'd0;
        else if (r != 3) start = (tree_count == 0) ? 6'd0 : 6'($urandom_range(0, tree_count - 1));
      end
      gap = ((n_rand / 16) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
      was_full = (tree_count >= TREE_SLOTS);
      send_item(act, val, ord, start, gap, (n_rand % 40) == 20);
      walk_tree(act, val, ord, start, 1'b1);
      // a dropped append changes nothing, so it is not counted
      if (!(act == atree_pkg::ACT_APPEND && was_full)) n_rand++;
    end
    s_axis_tvalid <= 1'b0;

    while (node_beats_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d items, %0d nodes stored, %0d appends dropped on a full store",
             items_sent, tree_count, drops);
    $display("walks pre %0d in %0d post %0d bad order %0d, %0d node beats checked",
             walks[0], walks[1], walks[2], walks[3], beats_seen);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
